/* hw/rtl/ftms_pkg.sv */
// Shared types, widths and helpers for the four-track minimum-spread selector.
package ftms_pkg;

  localparam int VAL_W      = 20;              // distance value width
  localparam int CHG_W      = 2;               // charge width, two's complement
  localparam int WORD_W     = VAL_W + CHG_W;   // stored track word {charge, value}
  localparam int STAT_W     = 2;
  localparam int OIDX_W     = 3;               // reported index width
  localparam int GROUP      = 4;               // tracks per subset
  localparam int KW         = $clog2(GROUP);
  localparam int SQ_W       = 2 * VAL_W;       // one squared value
  localparam int SUM_W      = VAL_W + 2;       // sum of four values
  localparam int SPREAD_W   = 46;
  localparam int CS_W       = 4;               // sum of four charges
  localparam int NUM_BANKS  = 2;               // event buffers in the track RAM
  localparam int BUSY_W     = $clog2(NUM_BANKS + 1);
  localparam int JOBQ_DEPTH = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NO_SUBSET = 2'd1,
    ST_TOO_FEW   = 2'd2
  } status_e;

  function automatic logic signed [CS_W-1:0] chg_ext(input logic [CHG_W-1:0] c);
    return {{(CS_W - CHG_W){c[CHG_W-1]}}, c};
  endfunction

endpackage

/* hw/rtl/ftms_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module ftms_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

/* hw/rtl/ftms_front.sv */
// Load side: accept tracks, write them to the current bank, queue a search job.
module ftms_front import ftms_pkg::*; #(
  parameter int MAX_TRACKS = 8,
  localparam int IW = $clog2(MAX_TRACKS),
  localparam int CW = $clog2(MAX_TRACKS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [VAL_W-1:0]  distance_value_i,
  input  logic [CHG_W-1:0]  track_charge_i,
  input  logic              last_track_i,
  input  logic              q_full_i,
  input  logic              bank_free_i,
  output logic              wr_en_o,
  output logic [IW:0]       wr_addr_o,
  output logic [WORD_W-1:0] wr_data_o,
  output logic              push_o,
  output logic              push_bank_o,
  output logic [CW-1:0]     push_count_o
);

  logic [CW-1:0]     count_q;
  logic              bank_q;
  logic [BUSY_W-1:0] busy_q, busy_d;
  logic              accept, has_room;
  logic [CW-1:0]     count_new;

  assign in_ready_o = (busy_q != BUSY_W'(NUM_BANKS)) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_room   = count_q < CW'(MAX_TRACKS);
  assign count_new  = has_room ? count_q + CW'(1) : count_q;

  // drop the word once the bank is full, but still honor its last mark
  assign wr_en_o   = accept && has_room;
  assign wr_addr_o = {bank_q, count_q[IW-1:0]};
  assign wr_data_o = {track_charge_i, distance_value_i};

  assign push_o       = accept && last_track_i;
  assign push_bank_o  = bank_q;
  assign push_count_o = count_new;

  always_comb begin
    busy_d = busy_q;
    if (push_o && !bank_free_i) begin
      busy_d = busy_q + BUSY_W'(1);
    end else if (!push_o && bank_free_i) begin
      busy_d = busy_q - BUSY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (push_o) begin
        count_q <= '0;
        bank_q  <= !bank_q;
      end else if (accept) begin
        count_q <= count_new;
      end
    end
  end

endmodule

/* hw/rtl/ftms_jobq.sv */
// Two-entry job queue between load side and search side.
module ftms_jobq import ftms_pkg::*; #(
  parameter int CW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          push_bank_i,
  input  logic [CW-1:0] push_count_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output logic          head_bank_o,
  output logic [CW-1:0] head_count_o
);

  localparam int PW = $clog2(JOBQ_DEPTH);
  localparam int NW = $clog2(JOBQ_DEPTH + 1);

  logic          bank_q  [JOBQ_DEPTH];
  logic [CW-1:0] count_q [JOBQ_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] fill_q;

  assign valid_o      = fill_q != '0;
  assign full_o       = fill_q == NW'(JOBQ_DEPTH);
  assign head_bank_o  = bank_q[rptr_q];
  assign head_count_o = count_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bank_q[wptr_q]  <= push_bank_i;
      count_q[wptr_q] <= push_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + NW'(1);
      end else if (!push_i && pop_i) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

/* hw/rtl/ftms_back.sv */
// Search side: walk all four-track subsets, keep the best, emit the results.
module ftms_back import ftms_pkg::*; #(
  parameter int MAX_TRACKS = 8,
  localparam int IW = $clog2(MAX_TRACKS),
  localparam int CW = $clog2(MAX_TRACKS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  logic              job_bank_i,
  input  logic [CW-1:0]     job_count_i,
  output logic              pop_o,
  output logic              bank_free_o,
  output logic [IW:0]       raddr0_o,
  output logic [IW:0]       raddr1_o,
  input  logic [WORD_W-1:0] rdata0_i,
  input  logic [WORD_W-1:0] rdata1_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [OIDX_W-1:0] track_index_o,
  output logic [VAL_W-1:0]  chosen_value_o,
  output logic              last_result_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  localparam int XW = CW + 1;

  state_e        state_q, state_d;
  logic [CW-1:0] n_q;
  logic          bank_q, half_q;
  logic [IW-1:0] ia_q, ib_q, ic_q, id_q;
  status_e       status_q;
  logic [KW-1:0] k_q;

  logic                found_q;
  logic [SPREAD_W-1:0] best_spread_q;
  logic [IW-1:0]       best_idx_q [GROUP];
  logic [VAL_W-1:0]    best_val_q [GROUP];

  // pipeline: R (RAM read) -> A (square) -> B (four-way sum) -> C (square of sum)
  //           -> D (spread) -> best compare
  logic                   r_vld_q, r_half_q;
  logic [IW-1:0]          r_idx_q [GROUP];
  logic                   a_vld_q, a_half_q;
  logic [SQ_W-1:0]        a_sq_q  [2];
  logic [VAL_W-1:0]       a_val_q [2];
  logic [CHG_W-1:0]       a_chg_q [2];
  logic [IW-1:0]          a_idx_q [GROUP];
  logic [SQ_W:0]          p_sq_q;
  logic [VAL_W:0]         p_sum_q;
  logic signed [CS_W-1:0] p_chg_q;
  logic [VAL_W-1:0]       p_val_q [2];
  logic                   b_vld_q, b_ok_q;
  logic [SQ_W+1:0]        b_sq_q;
  logic [SUM_W-1:0]       b_sum_q;
  logic [VAL_W-1:0]       b_val_q [GROUP];
  logic [IW-1:0]          b_idx_q [GROUP];
  logic                   c_vld_q;
  logic [2*SUM_W-1:0]     c_ss_q;
  logic [SQ_W+3:0]        c_sq4_q;
  logic [VAL_W-1:0]       c_val_q [GROUP];
  logic [IW-1:0]          c_idx_q [GROUP];
  logic                   d_vld_q;
  logic [SPREAD_W-1:0]    d_spread_q;
  logic [VAL_W-1:0]       d_val_q [GROUP];
  logic [IW-1:0]          d_idx_q [GROUP];

  logic                   out_vld_q;
  logic [STAT_W-1:0]      out_status_q;
  logic [OIDX_W-1:0]      out_idx_q;
  logic [VAL_W-1:0]       out_val_q;
  logic                   out_last_q;

  logic too_few, d_more, c_more, b_more, a_more, last_combo;
  logic pipe_empty, ld, emit_last, upd;
  logic [VAL_W-1:0] rv0, rv1;
  logic [CHG_W-1:0] rc0, rc1;

  assign rv0 = rdata0_i[VAL_W-1:0];
  assign rv1 = rdata1_i[VAL_W-1:0];
  assign rc0 = rdata0_i[WORD_W-1:VAL_W];
  assign rc1 = rdata1_i[WORD_W-1:VAL_W];

  assign too_few = job_count_i < CW'(GROUP);

  // lexicographic successor of (a, b, c, d)
  assign d_more = (XW'(id_q) + XW'(1)) < XW'(n_q);
  assign c_more = (XW'(ic_q) + XW'(2)) < XW'(n_q);
  assign b_more = (XW'(ib_q) + XW'(3)) < XW'(n_q);
  assign a_more = (XW'(ia_q) + XW'(4)) < XW'(n_q);
  assign last_combo = !(d_more || c_more || b_more || a_more);

  assign raddr0_o = {bank_q, half_q ? ic_q : ia_q};
  assign raddr1_o = {bank_q, half_q ? id_q : ib_q};

  assign pipe_empty = !(r_vld_q || a_vld_q || b_vld_q || c_vld_q || d_vld_q);
  assign ld         = !out_vld_q || out_ready_i;
  assign emit_last  = (status_q != ST_FOUND) || (k_q == KW'(GROUP - 1));
  assign upd        = d_vld_q && (!found_q || (d_spread_q < best_spread_q));

  assign pop_o       = (state_q == S_IDLE) && job_valid_i;
  assign bank_free_o = (pop_o && too_few) || ((state_q == S_DRAIN) && pipe_empty);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = too_few ? S_EMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (half_q && last_combo) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (ld && emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      n_q           <= '0;
      bank_q        <= 1'b0;
      half_q        <= 1'b0;
      ia_q          <= '0;
      ib_q          <= '0;
      ic_q          <= '0;
      id_q          <= '0;
      status_q      <= ST_FOUND;
      k_q           <= '0;
      found_q       <= 1'b0;
      best_spread_q <= '1;
      r_vld_q       <= 1'b0;
      r_half_q      <= 1'b0;
      a_vld_q       <= 1'b0;
      a_half_q      <= 1'b0;
      b_vld_q       <= 1'b0;
      c_vld_q       <= 1'b0;
      d_vld_q       <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      r_vld_q  <= state_q == S_SEARCH;
      r_half_q <= half_q;
      a_vld_q  <= r_vld_q;
      a_half_q <= r_half_q;
      b_vld_q  <= a_vld_q && a_half_q;
      c_vld_q  <= b_vld_q && b_ok_q;
      d_vld_q  <= c_vld_q;
      if (upd) begin
        found_q       <= 1'b1;
        best_spread_q <= d_spread_q;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            n_q           <= job_count_i;
            bank_q        <= job_bank_i;
            ia_q          <= IW'(0);
            ib_q          <= IW'(1);
            ic_q          <= IW'(2);
            id_q          <= IW'(3);
            half_q        <= 1'b0;
            k_q           <= '0;
            found_q       <= 1'b0;
            best_spread_q <= '1;
            status_q      <= too_few ? ST_TOO_FEW : ST_FOUND;
          end
        end
        S_SEARCH: begin
          half_q <= !half_q;
          if (half_q) begin
            if (d_more) begin
              id_q <= id_q + IW'(1);
            end else if (c_more) begin
              ic_q <= ic_q + IW'(1);
              id_q <= ic_q + IW'(2);
            end else if (b_more) begin
              ib_q <= ib_q + IW'(1);
              ic_q <= ib_q + IW'(2);
              id_q <= ib_q + IW'(3);
            end else if (a_more) begin
              ia_q <= ia_q + IW'(1);
              ib_q <= ia_q + IW'(2);
              ic_q <= ia_q + IW'(3);
              id_q <= ia_q + IW'(4);
            end
          end
        end
        S_DRAIN: begin
          if (pipe_empty) begin
            status_q <= found_q ? ST_FOUND : ST_NO_SUBSET;
          end
        end
        S_EMIT: begin
          if (ld) begin
            k_q <= k_q + KW'(1);
          end
        end
        default: ;
      endcase
      if (ld) begin
        out_vld_q <= state_q == S_EMIT;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    // R: indices that go with this read
    r_idx_q[0] <= ia_q;
    r_idx_q[1] <= ib_q;
    r_idx_q[2] <= ic_q;
    r_idx_q[3] <= id_q;
    // A: square both words
    a_sq_q[0]  <= SQ_W'(rv0) * SQ_W'(rv0);
    a_sq_q[1]  <= SQ_W'(rv1) * SQ_W'(rv1);
    a_val_q[0] <= rv0;
    a_val_q[1] <= rv1;
    a_chg_q[0] <= rc0;
    a_chg_q[1] <= rc1;
    a_idx_q    <= r_idx_q;
    // B: hold the first pair, fold in the second
    if (a_vld_q && !a_half_q) begin
      p_sq_q     <= (SQ_W + 1)'(a_sq_q[0]) + (SQ_W + 1)'(a_sq_q[1]);
      p_sum_q    <= (VAL_W + 1)'(a_val_q[0]) + (VAL_W + 1)'(a_val_q[1]);
      p_chg_q    <= chg_ext(a_chg_q[0]) + chg_ext(a_chg_q[1]);
      p_val_q[0] <= a_val_q[0];
      p_val_q[1] <= a_val_q[1];
    end
    b_sq_q     <= (SQ_W + 2)'(p_sq_q) + (SQ_W + 2)'(a_sq_q[0]) + (SQ_W + 2)'(a_sq_q[1]);
    b_sum_q    <= SUM_W'(p_sum_q) + SUM_W'(a_val_q[0]) + SUM_W'(a_val_q[1]);
    b_ok_q     <= (p_chg_q + chg_ext(a_chg_q[0]) + chg_ext(a_chg_q[1])) == '0;
    b_val_q[0] <= p_val_q[0];
    b_val_q[1] <= p_val_q[1];
    b_val_q[2] <= a_val_q[0];
    b_val_q[3] <= a_val_q[1];
    b_idx_q    <= a_idx_q;
    // C: square of the sum, four times the sum of squares
    c_ss_q  <= (2 * SUM_W)'(b_sum_q) * (2 * SUM_W)'(b_sum_q);
    c_sq4_q <= {b_sq_q, 2'b00};
    c_val_q <= b_val_q;
    c_idx_q <= b_idx_q;
    // D: spread
    d_spread_q <= SPREAD_W'(c_sq4_q) - SPREAD_W'(c_ss_q);
    d_val_q    <= c_val_q;
    d_idx_q    <= c_idx_q;
    // keep the best subset
    if (upd) begin
      best_idx_q <= d_idx_q;
      best_val_q <= d_val_q;
    end
    // output word
    if (ld && (state_q == S_EMIT)) begin
      out_status_q <= status_q;
      out_last_q   <= emit_last;
      if (status_q == ST_FOUND) begin
        out_idx_q <= OIDX_W'(best_idx_q[k_q]);
        out_val_q <= best_val_q[k_q];
      end else begin
        out_idx_q <= '0;
        out_val_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign track_index_o  = out_idx_q;
  assign chosen_value_o = out_val_q;
  assign last_result_o  = out_last_q;

endmodule

/* hw/rtl/four_track_min_spread_select_top.sv */
// Top level of the four-track minimum-spread selector.
//
// Tracks arrive one word per cycle on the input channel and go into one of two
// banks of a small track RAM; the word marked last_track closes the event and
// queues a search job, and the next event may load into the other bank while
// that search runs (loading stalls only while both banks hold events not yet
// searched). Up to MAX_TRACKS tracks are kept per event; further tracks are
// dropped, but their last mark still closes the event. The search visits every
// four-track subset in lexicographic order, reading each subset as two pairs of
// tracks, one RAM read of two tracks per cycle on the RAM's two read ports, and
// then drains the arithmetic pipeline. Results then leave through an output
// register at up to one word per cycle, as out_ready allows: four words
// (status 0, ascending index, last_result on the fourth) for the zero-charge
// subset with the smallest 4*sum(x^2)-(sum x)^2, earliest subset on a tie, or
// one status word (1 no zero-charge subset, 2 fewer than four tracks). The
// throughput for a full eight-track event is set by the two-port track RAM.
module four_track_min_spread_select_top import ftms_pkg::*; #(
  parameter int MAX_TRACKS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [VAL_W-1:0]        distance_value_i,
  input  logic signed [CHG_W-1:0] track_charge_i,
  input  logic                    last_track_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [OIDX_W-1:0]       track_index_o,
  output logic [VAL_W-1:0]        chosen_value_o,
  output logic                    last_result_o
);

  localparam int IW        = $clog2(MAX_TRACKS);
  localparam int CW        = $clog2(MAX_TRACKS + 1);
  localparam int RAM_DEPTH = NUM_BANKS << IW;

  // load side -> RAM
  logic              wr_en;
  logic [IW:0]       wr_addr;
  logic [WORD_W-1:0] wr_data;
  // load side -> job queue -> search side
  logic              push, push_bank, q_full;
  logic [CW-1:0]     push_count;
  logic              job_valid, job_bank, pop, bank_free;
  logic [CW-1:0]     job_count;
  // search side <-> RAM
  logic [IW:0]       raddr0, raddr1;
  logic [WORD_W-1:0] rdata0, rdata1;

  ftms_front #(.MAX_TRACKS(MAX_TRACKS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .distance_value_i,
    .track_charge_i   (track_charge_i),
    .last_track_i,
    .q_full_i         (q_full),
    .bank_free_i      (bank_free),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .push_o           (push),
    .push_bank_o      (push_bank),
    .push_count_o     (push_count)
  );

  ftms_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i,
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  ftms_jobq #(.CW(CW)) u_jobq (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_bank_i  (push_bank),
    .push_count_i (push_count),
    .pop_i        (pop),
    .valid_o      (job_valid),
    .full_o       (q_full),
    .head_bank_o  (job_bank),
    .head_count_o (job_count)
  );

  ftms_back #(.MAX_TRACKS(MAX_TRACKS)) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i    (job_valid),
    .job_bank_i     (job_bank),
    .job_count_i    (job_count),
    .pop_o          (pop),
    .bank_free_o    (bank_free),
    .raddr0_o       (raddr0),
    .raddr1_o       (raddr1),
    .rdata0_i       (rdata0),
    .rdata1_i       (rdata1),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .track_index_o,
    .chosen_value_o,
    .last_result_o
  );

  // never queue a job on top of a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // a status-only word always closes its event
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_FOUND)) |-> last_result_o)
    else $error("status word without last_result");

  // the four words of a found subset follow without a gap
  a_found_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (status_o == ST_FOUND) && !last_result_o)
      |=> out_valid_o)
    else $error("gap inside a found-subset burst");

endmodule
